FILE: design/hds_pkg.sv
package hds_pkg;

   // grid geometry
   localparam int MAX_WIDTH    = 256;
   localparam int HEIGHT_LIMIT = 256;
   localparam int MIN_GEOM     = 3;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

   // field and register widths
   localparam int DATA_W = 32;
   localparam int GAIN_W = 17;
   localparam int GEOM_W = 9;

   // datapath widths
   localparam int LAP_W  = 36;
   localparam int HALF_W = LAP_W / 2;
   localparam int FRAC_W = 16;
   localparam int PP_LO_W = GAIN_W + HALF_W;
   localparam int PP_HI_W = GAIN_W + HALF_W + 1;
   localparam int PROD_W  = GAIN_W + LAP_W + 1;
   localparam int Q_W     = PROD_W - FRAC_W;
   localparam int SUM_W   = Q_W + 1;

   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd42950;
   localparam logic [GEOM_W-1:0] GEOM_RESET = 9'd256;

   // per-item control carried down the pipeline
   typedef struct packed {
      logic emit_inner;  // item releases the cell of the row above
      logic emit_edge;   // item sits in the last row and releases itself
      logic pass;        // released cell is a border cell, no update
      logic last_col;
   } ctl_type;

   // one line buffer word: rows r-2 and r-1 of one column
   typedef struct packed {
      logic [DATA_W-1:0] older;
      logic [DATA_W-1:0] prev;
   } col_pair_type;

endpackage

FILE: design/hds_linebuf.sv
module hds_linebuf
   import hds_pkg::*;
(
   input  logic                clock,
   input  logic                rd_en,
   input  logic [COL_W-1:0]    rd_addr,
   output col_pair_type        rd_pair,
   output logic [DATA_W-1:0]   rd_right,
   input  logic                wr_en,
   input  logic [COL_W-1:0]    wr_addr,
   input  col_pair_type        wr_pair
);

   col_pair_type      mem [MAX_WIDTH];
   col_pair_type      rd_pair_ff;
   logic [DATA_W-1:0] rd_right_ff;
   logic [COL_W-1:0]  next_addr;

   // wrap the lookahead address; its data is unused in the last column
   assign next_addr = (int'(rd_addr) == MAX_WIDTH - 1) ? '0 : rd_addr + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_pair;
      end
      if (rd_en) begin
         rd_pair_ff  <= mem[rd_addr];
         rd_right_ff <= mem[next_addr].prev;
      end
   end

   assign rd_pair  = rd_pair_ff;
   assign rd_right = rd_right_ff;

endmodule

FILE: design/hds_arith.sv
module hds_arith
   import hds_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  ctl_type                    in_ctl,
   input  logic [GAIN_W-1:0]          gain,
   input  logic signed [DATA_W-1:0]   center,
   input  logic signed [DATA_W-1:0]   up,
   input  logic signed [DATA_W-1:0]   down,
   input  logic signed [DATA_W-1:0]   left,
   input  logic signed [DATA_W-1:0]   right,
   output logic                       out_valid,
   output ctl_type                    out_ctl,
   output logic [DATA_W-1:0]          out_value,
   output logic [DATA_W-1:0]          out_cell
);

   // stage 1: Laplacian
   logic                       s1_valid_ff;
   ctl_type                    s1_ctl_ff;
   logic signed [DATA_W-1:0]   s1_center_ff;
   logic [DATA_W-1:0]          s1_cell_ff;
   logic signed [LAP_W-1:0]    s1_lap_ff;
   logic signed [LAP_W-1:0]    s1_lap_in;

   // stage 2: partial products of gain * Laplacian
   logic                       s2_valid_ff;
   ctl_type                    s2_ctl_ff;
   logic signed [DATA_W-1:0]   s2_center_ff;
   logic [DATA_W-1:0]          s2_cell_ff;
   logic [PP_LO_W-1:0]         s2_pp_lo_ff;
   logic signed [PP_HI_W-1:0]  s2_pp_hi_ff;
   logic [PP_LO_W-1:0]         s2_pp_lo_in;
   logic signed [PP_HI_W-1:0]  s2_pp_hi_in;

   // result assembly
   logic signed [PROD_W-1:0]   prod;
   logic signed [Q_W-1:0]      step;
   logic signed [SUM_W-1:0]    sum;
   logic [DATA_W-1:0]          sat;

   assign s1_lap_in = LAP_W'(up) + LAP_W'(down) + LAP_W'(left) + LAP_W'(right)
                    - (LAP_W'(center) <<< 2);

   assign s2_pp_lo_in = PP_LO_W'(gain) * PP_LO_W'(s1_lap_ff[HALF_W-1:0]);
   assign s2_pp_hi_in = PP_HI_W'($signed({1'b0, gain}))
                      * PP_HI_W'($signed(s1_lap_ff[LAP_W-1:HALF_W]));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s1_ctl_ff    <= in_ctl;
         s1_center_ff <= center;
         s1_cell_ff   <= down;
         s1_lap_ff    <= s1_lap_in;
         s2_ctl_ff    <= s1_ctl_ff;
         s2_center_ff <= s1_center_ff;
         s2_cell_ff   <= s1_cell_ff;
         s2_pp_lo_ff  <= s2_pp_lo_in;
         s2_pp_hi_ff  <= s2_pp_hi_in;
      end
   end

   // round to nearest, ties up, then floor shift
   assign prod = (PROD_W'(s2_pp_hi_ff) <<< HALF_W) + $signed(PROD_W'(s2_pp_lo_ff))
               + $signed(PROD_W'(1) <<< (FRAC_W - 1));
   assign step = prod[PROD_W-1:FRAC_W];
   assign sum  = SUM_W'(s2_center_ff) + SUM_W'(step);

   always_comb begin
      if (sum[SUM_W-1] && !(&sum[SUM_W-2:DATA_W-1])) begin
         sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else if (!sum[SUM_W-1] && (|sum[SUM_W-2:DATA_W-1])) begin
         sat = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sat = sum[DATA_W-1:0];
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_ctl   = s2_ctl_ff;
   assign out_value = s2_ctl_ff.pass ? s2_center_ff : sat;
   assign out_cell  = s2_cell_ff;

endmodule

FILE: design/heat_diffusion_stencil_step.sv
// Heat diffusion stencil: one explicit time step of the 2D heat equation over a
// grid that streams in raster order, one signed Q15.16 cell per req transfer.
// Interior cells get cell + gain*(up+down+left+right-4*cell), rounded and
// saturated; border cells leave unchanged. The host repeats passes for more steps.
// Results lag the input by one row: the cell at (r, c) with r >= 1 releases the
// result for (r-1, c); row zero releases nothing; every cell of the last row
// then also releases itself, with rsp_grid_done high on the final cell.
// A transfer's first result reaches rsp through the input register, Laplacian
// register, product register and result register. Throughput: one req transfer
// per cycle unless the result register stalls; a last-row cell holds the result
// register until both of its results have gone out, since it releases two results.
// Both line buffers live in one 64-bit-wide memory with one write port and two
// read ports, read at the current and the next column.
// Reset: gain, grid_width and grid_height take their defaults and the grid
// position returns to the first cell; line buffer contents are not cleared,
// since every word is written during row zero before any read uses it.
// Writing grid_width or grid_height restarts the grid at its first cell.
// Stall: while rsp_ready is low and a result waits, the whole pipeline holds
// and req_ready drops; no data is lost or repeated.
module heat_diffusion_stencil_step
   import hds_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_cell_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_new_value,
   output logic                     rsp_grid_done,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [GAIN_W-1:0]        csr_wdata
);

   // configuration
   logic [GAIN_W-1:0] gain_ff;
   logic [GEOM_W-1:0] grid_width_ff;
   logic [GEOM_W-1:0] grid_height_ff;
   logic [COL_W-1:0]  width_last;
   logic [ROW_W-1:0]  height_last;

   // position of the next input cell
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              at_last_col;
   logic              at_last_row;

   // input register
   logic              s0_valid_ff;
   logic [DATA_W-1:0] s0_cell_ff;
   logic [COL_W-1:0]  s0_col_ff;
   ctl_type           s0_ctl_ff;
   ctl_type           ctl_in;
   logic [DATA_W-1:0] left_ff;

   // line buffer ports
   col_pair_type      rd_pair;
   logic [DATA_W-1:0] rd_right;
   logic              wr_en;
   col_pair_type      wr_pair;

   // datapath result
   logic              ar_valid;
   ctl_type           ar_ctl;
   logic [DATA_W-1:0] ar_value;
   logic [DATA_W-1:0] ar_cell;

   // result register: the updated cell of the row above, then the own edge cell
   logic              out_inner_v_ff;
   logic [DATA_W-1:0] out_inner_ff;
   logic              out_edge_v_ff;
   logic [DATA_W-1:0] out_edge_ff;
   logic              out_done_ff;

   logic              advance;
   logic              req_fire;
   logic              rsp_fire;

   // clamp the geometry to its legal range, as last index
   always_comb begin
      if (int'(grid_width_ff) < MIN_GEOM) begin
         width_last = COL_W'(MIN_GEOM - 1);
      end else if (int'(grid_width_ff) > MAX_WIDTH) begin
         width_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_last = COL_W'(grid_width_ff - 1'b1);
      end
      if (int'(grid_height_ff) < MIN_GEOM) begin
         height_last = ROW_W'(MIN_GEOM - 1);
      end else if (int'(grid_height_ff) > HEIGHT_LIMIT) begin
         height_last = ROW_W'(HEIGHT_LIMIT - 1);
      end else begin
         height_last = ROW_W'(grid_height_ff - 1'b1);
      end
   end

   assign at_last_col = (col_ff == width_last);
   assign at_last_row = (row_ff == height_last);

   // the pipeline moves as one whenever the result register frees up this cycle
   assign advance   = (!out_inner_v_ff && !out_edge_v_ff)
                   || (rsp_ready && (out_inner_v_ff ^ out_edge_v_ff));
   assign req_ready = advance;
   assign req_fire  = req_valid && advance;
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      ctl_in.emit_inner = (row_ff != '0);
      ctl_in.emit_edge  = at_last_row;
      ctl_in.pass       = (row_ff == ROW_W'(1)) || (col_ff == '0) || at_last_col;
      ctl_in.last_col   = at_last_col;
   end

   // configuration writes and grid position
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff        <= GAIN_RESET;
         grid_width_ff  <= GEOM_RESET;
         grid_height_ff <= GEOM_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GAIN: begin
               gain_ff <= csr_wdata;
            end
            CSR_WIDTH: begin
               grid_width_ff <= csr_wdata[GEOM_W-1:0];
               col_ff        <= '0;
               row_ff        <= '0;
            end
            CSR_HEIGHT: begin
               grid_height_ff <= csr_wdata[GEOM_W-1:0];
               col_ff         <= '0;
               row_ff         <= '0;
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end else if (req_fire) begin
         if (at_last_col) begin
            col_ff <= '0;
            row_ff <= at_last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // input register; the line buffer read lands alongside it
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_fire;
      end
      if (req_fire) begin
         s0_cell_ff <= req_cell_value;
         s0_col_ff  <= col_ff;
         s0_ctl_ff  <= ctl_in;
      end
      // the left neighbor is the row r-1 cell of the item just before
      if (s0_valid_ff && advance) begin
         left_ff <= rd_pair.prev;
      end
   end

   // retire the item leaving the input register into the line buffer
   assign wr_en        = s0_valid_ff && advance;
   assign wr_pair.older = rd_pair.prev;
   assign wr_pair.prev  = s0_cell_ff;

   hds_linebuf u_linebuf (
      .clock    (clock),
      .rd_en    (req_fire),
      .rd_addr  (col_ff),
      .rd_pair  (rd_pair),
      .rd_right (rd_right),
      .wr_en    (wr_en),
      .wr_addr  (s0_col_ff),
      .wr_pair  (wr_pair)
   );

   hds_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_ctl    (s0_ctl_ff),
      .gain      (gain_ff),
      .center    (rd_pair.prev),
      .up        (rd_pair.older),
      .down      (s0_cell_ff),
      .left      (left_ff),
      .right     (rd_right),
      .out_valid (ar_valid),
      .out_ctl   (ar_ctl),
      .out_value (ar_value),
      .out_cell  (ar_cell)
   );

   // result register: load on advance, otherwise drain one slot per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_inner_v_ff <= 1'b0;
         out_edge_v_ff  <= 1'b0;
      end else if (advance) begin
         out_inner_v_ff <= ar_valid && ar_ctl.emit_inner;
         out_edge_v_ff  <= ar_valid && ar_ctl.emit_edge;
      end else if (rsp_fire) begin
         // both slots are full here; the inner result goes first
         out_inner_v_ff <= 1'b0;
      end
      if (advance) begin
         out_inner_ff <= ar_value;
         out_edge_ff  <= ar_cell;
         out_done_ff  <= ar_ctl.last_col;
      end
   end

   assign rsp_valid     = out_inner_v_ff || out_edge_v_ff;
   assign rsp_new_value = out_inner_v_ff ? out_inner_ff : out_edge_ff;
   assign rsp_grid_done = out_inner_v_ff ? 1'b0 : out_done_ff;

   // a full result register must hold off the input side
   assert property (@(posedge clock) disable iff (reset)
      (out_inner_v_ff && out_edge_v_ff) |-> !req_ready)
      else $error("input taken while both result slots are full");

   // the grid position stays inside the clamped geometry
   assert property (@(posedge clock) disable iff (reset)
      (col_ff <= width_last) && (row_ff <= height_last))
      else $error("grid position outside the configured grid");

   // the pending line buffer write never hits the word being read
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && req_fire) |-> (s0_col_ff != col_ff))
      else $error("line buffer write collides with read");

   // grid_done only rides on a last-row edge cell
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_grid_done) |-> (out_edge_v_ff && !out_inner_v_ff))
      else $error("grid_done without a last-row cell");

endmodule

FILE: dv/heat_diffusion_stencil_step_tb.sv
`timescale 1ns / 100ps

module heat_diffusion_stencil_step_tb;
   import hds_pkg::*;

   // Run length guard: the slowest legal run is roughly 2000 cells, so CYCLE_LIMIT
   // leaves ample room.
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_TICKS = 12;     // pipeline is four registers deep
   localparam int RANDOM_CELLS = 1600;

   // Index with no register behind it; the block must ignore writes to it.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [DATA_W-1:0] CELL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] CELL_MIN = 32'sh8000_0000;
   localparam longint SAT_HI = (longint'(1) <<< (DATA_W - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) <<< (DATA_W - 1));
   localparam longint ROUND_HALF = longint'(1) <<< (FRAC_W - 1);

   typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_kind_type;

   // One cell waiting to be sent: payload, the gap ahead of it, and whether
   // it must wait until every outstanding result has drained.
   typedef struct {
      logic signed [DATA_W-1:0] value;
      int                       gap;
      bit                       drain;
   } cell_item_type;

   // One predicted result.
   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     done;
   } stencil_out_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_cell_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready      = 1'b0;
   logic signed [DATA_W-1:0] rsp_new_value;
   logic                     rsp_grid_done;
   logic                     csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index      = '0;
   logic [GAIN_W-1:0]        csr_wdata      = '0;

   heat_diffusion_stencil_step dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_value  (rsp_new_value),
      .rsp_grid_done  (rsp_grid_done),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   cell_item_type   cell_queue[$];
   stencil_out_type expected_cells[$];
   idle_kind_type   idle_mode = IDLE_FULL;
   int              mismatches = 0;
   int              cycle_count;

   // transfer flags seen at the last rising edge, read at the falling edge
   bit req_xfer = 1'b0;
   bit rsp_xfer = 1'b0;
   int gap_left = 0;
   bit gap_armed = 1'b0;
   int stall_left = 0;

   // Predictor state: configuration, both line buffers and grid position.
   logic [GAIN_W-1:0]        gain_reg;
   logic [GEOM_W-1:0]        width_reg;
   logic [GEOM_W-1:0]        height_reg;
   logic signed [DATA_W-1:0] upper_line [MAX_WIDTH];   // row r-2
   logic signed [DATA_W-1:0] middle_line[MAX_WIDTH];   // row r-1
   int                       col_at;
   int                       row_at;

   function automatic int draw_wait();
      case (idle_mode)
         IDLE_NONE:   return 0;
         IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
         default:     return $urandom_range(0, 15);
      endcase
   endfunction

   function automatic int clamp_geom(input logic [GEOM_W-1:0] v, input int hi);
      int n;
      n = int'(v);
      if (n < MIN_GEOM) n = MIN_GEOM;
      if (n > hi) n = hi;
      return n;
   endfunction

   // Five-point update: center + round(gain * laplacian), ties toward plus
   // infinity, saturated to the 32-bit range.
   function automatic logic signed [DATA_W-1:0] diffuse_cell(
         input logic [GAIN_W-1:0] g, input longint center, input longint up,
         input longint down, input longint left, input longint right);
      longint lap, acc, sum;
      lap = up + down + left + right - 4 * center;
      acc = longint'(g) * lap + ROUND_HALF;
      sum = center + (acc >>> FRAC_W);
      if (sum > SAT_HI) sum = SAT_HI;
      if (sum < SAT_LO) sum = SAT_LO;
      return sum[DATA_W-1:0];
   endfunction

   // Advance the predictor by one accepted cell and queue what it releases.
   task automatic predict_cell(input logic signed [DATA_W-1:0] cell_value);
      int              w, h, c, r;
      bit              last_row, last_col;
      stencil_out_type res;
      w = clamp_geom(width_reg, MAX_WIDTH);
      h = clamp_geom(height_reg, HEIGHT_LIMIT);
      c = (col_at >= w) ? w - 1 : col_at;
      r = (row_at >= h) ? h - 1 : row_at;
      last_row = (r == h - 1);
      last_col = (c == w - 1);
      // release the cell one row up; border cells go out untouched
      if (r >= 1) begin
         res.done = 1'b0;
         if (r == 1 || c == 0 || last_col) begin
            res.value = middle_line[c];
         end else begin
            res.value = diffuse_cell(gain_reg, middle_line[c], upper_line[c], cell_value,
                                     upper_line[c-1], middle_line[c+1]);
         end
         expected_cells.push_back(res);
      end
      // last row is border too: release it as it arrives
      if (last_row) begin
         res.value = cell_value;
         res.done  = last_col;
         expected_cells.push_back(res);
      end
      upper_line[c]  = middle_line[c];
      middle_line[c] = cell_value;
      if (last_col) begin
         col_at = 0;
         row_at = last_row ? 0 : r + 1;
      end else begin
         col_at = c + 1;
         row_at = r;
      end
   endtask

   // Rising edge: track transfers, mirror register writes, predict, check.
   always @(posedge clock) begin
      stencil_out_type want;
      req_xfer <= !reset && req_valid && req_ready;
      rsp_xfer <= !reset && rsp_valid && rsp_ready;
      if (reset) begin
         gain_reg   = GAIN_RESET;
         width_reg  = GEOM_RESET;
         height_reg = GEOM_RESET;
         col_at     = 0;
         row_at     = 0;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               $error("new_value: expected nothing, got %0d", rsp_new_value);
               mismatches++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_new_value !== want.value) begin
                  $error("new_value: expected %0d, got %0d", want.value, rsp_new_value);
                  mismatches++;
               end
               if (rsp_grid_done !== want.done) begin
                  $error("grid_done: expected %0b, got %0b", want.done, rsp_grid_done);
                  mismatches++;
               end
            end
         end
         // geometry writes restart the grid; gain keeps the position
         if (csr_write_en) begin
            case (csr_index)
               CSR_GAIN: gain_reg = csr_wdata;
               CSR_WIDTH: begin
                  width_reg = csr_wdata[GEOM_W-1:0];
                  col_at = 0;
                  row_at = 0;
               end
               CSR_HEIGHT: begin
                  height_reg = csr_wdata[GEOM_W-1:0];
                  col_at = 0;
                  row_at = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_cell(req_cell_value);
      end
   end

   // Driver: hold the payload until the transfer, then drop the sent cell,
   // wait out the next cell's gap and present it.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_armed = 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (req_xfer) void'(cell_queue.pop_front());
         if (!gap_armed && cell_queue.size() != 0) begin
            gap_left  = cell_queue[0].gap;
            gap_armed = 1'b1;
         end
         if (gap_armed && gap_left == 0 &&
             (!cell_queue[0].drain || expected_cells.size() == 0)) begin
            req_valid      <= 1'b1;
            req_cell_value <= cell_queue[0].value;
            gap_armed = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (gap_armed && gap_left > 0) gap_left--;
         end
      end
   end

   // Receiver: after each result transfer, stall for a freshly drawn count.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_xfer) stall_left = draw_wait();
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_cell(input logic signed [DATA_W-1:0] value, input bit drain);
      cell_item_type item;
      item.value = value;
      item.gap   = draw_wait();
      item.drain = drain;
      cell_queue.push_back(item);
   endtask

   function automatic logic signed [DATA_W-1:0] random_cell();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         2:       return $urandom_range(0, 1) ? CELL_MAX - $urandom_range(0, 255)
                                              : CELL_MIN + $urandom_range(0, 255);
         default: return $signed($urandom) >>> $urandom_range(4, 24);
      endcase
   endfunction

   // geometry word with random junk above the 9 bits the block uses
   function automatic logic [GAIN_W-1:0] geom_word(input logic [GEOM_W-1:0] raw);
      logic [GAIN_W-1:0] word;
      word = GAIN_W'($urandom);
      word[GEOM_W-1:0] = raw;
      return word;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Wait until every cell is sent and every result is back, then give the
   // pipeline time to flush cells that release nothing.
   task automatic settle();
      do @(negedge clock);
      while (cell_queue.size() != 0 || req_valid || expected_cells.size() != 0);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int                unsigned n;
      int                phase;
      int                total_cells;
      int                grid_cells;
      logic [GEOM_W-1:0] w_raw;
      logic [GEOM_W-1:0] h_raw;
      logic [GAIN_W-1:0] g;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset geometry is 256 wide: two cells of row zero release nothing.
      queue_cell(CELL_MAX, 1'b0);
      queue_cell(CELL_MIN, 1'b0);
      settle();

      // Full gain on a 3x3 checkerboard of the extremes: the only interior
      // cell drives the update hard into saturation.
      write_csr(CSR_GAIN, {GAIN_W{1'b1}});
      write_csr(CSR_WIDTH, geom_word(9'd3));
      write_csr(CSR_HEIGHT, geom_word(9'd3));
      for (int i = 0; i < 9; i++) queue_cell((i % 2 == 0) ? CELL_MIN : CELL_MAX, 1'b0);
      settle();

      // Half gain, laplacian of +1 and -1: rounding ties go toward plus
      // infinity. Height 0 clamps to 3. Hold one cell until the pipe drains.
      write_csr(CSR_UNUSED, GAIN_W'($urandom));
      write_csr(CSR_GAIN, 17'd32768);
      write_csr(CSR_WIDTH, geom_word(9'd4));
      write_csr(CSR_HEIGHT, geom_word(9'd0));
      queue_cell(32'sd0, 1'b0);
      queue_cell(32'sd1, 1'b0);
      queue_cell(-32'sd1, 1'b0);
      for (int i = 3; i < 12; i++) queue_cell(32'sd0, i == 6);
      settle();

      // Random phases: mostly small grids, one phase at the largest width and one
      // at the largest height. Only the last write is seen per phase.
      phase = 0;
      total_cells = 0;
      w_raw = 9'd4;
      h_raw = 9'd0;
      while (total_cells < RANDOM_CELLS || phase < 6) begin
         idle_mode = idle_kind_type'($urandom_range(0, 2));
         if (phase == 2 || phase == 5) begin
            write_csr(CSR_GAIN, GAIN_W'($urandom));
            if (phase == 2) begin
               w_raw = GEOM_W'(9'd256 + $urandom_range(0, 255));
               h_raw = 9'd3;
            end else begin
               w_raw = GEOM_W'($urandom_range(0, 3));
               h_raw = GEOM_W'(9'd256 + $urandom_range(0, 255));
            end
            write_csr(CSR_WIDTH, geom_word(w_raw));
            write_csr(CSR_HEIGHT, geom_word(h_raw));
            n = clamp_geom(w_raw, MAX_WIDTH) * clamp_geom(h_raw, HEIGHT_LIMIT);
         end else begin
            if ($urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 3))
                  0:       g = '0;
                  1:       g = {GAIN_W{1'b1}};
                  default: g = GAIN_W'($urandom);
               endcase
               write_csr(CSR_GAIN, g);
            end
            // skip geometry now and then so the grid carries across a gain change
            if ($urandom_range(0, 2) != 0) begin
               w_raw = GEOM_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                           : $urandom_range(3, 10));
               write_csr(CSR_WIDTH, geom_word(w_raw));
            end
            if ($urandom_range(0, 2) != 0) begin
               h_raw = GEOM_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                           : $urandom_range(3, 10));
               write_csr(CSR_HEIGHT, geom_word(h_raw));
            end
            if ($urandom_range(0, 7) == 0) write_csr(CSR_UNUSED, GAIN_W'($urandom));
            grid_cells = clamp_geom(w_raw, MAX_WIDTH) * clamp_geom(h_raw, HEIGHT_LIMIT);
            n = $urandom_range(1, 3) * grid_cells;
            // leave a partial grid behind now and then
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, grid_cells - 1);
         end
         total_cells += n;
         for (int i = 0; i < n; i++) queue_cell(random_cell(), $urandom_range(0, 99) == 0);
         settle();
         phase++;
      end

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
